// ----- hdl/f2fq_pkg.sv -----
// Package: widths, register indexes, reset values and the configuration struct for the quantizer.
`timescale 1ns / 1ps
`default_nettype none
package f2fq_pkg;
  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned FIXED_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_EXP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED     = 2'd2;
  localparam logic signed [6:0] SCALE_EXP_RST = 7'sd0;
  localparam logic [5:0]        OUT_WIDTH_RST = 6'd8;
  localparam logic              SIGNED_RST    = 1'b1;

  typedef struct packed {
    logic signed [6:0] scale_exp;
    logic [5:0]        width;     // already clamped to 2..32
    logic              is_signed;
  } cfg_t;
endpackage
`default_nettype wire

// ----- hdl/float_to_fixed_quantizer.sv -----
// Float-to-fixed quantizer top level: input and result registers around the core.
// Converts single-precision words to integers of out_width bits scaled by
// 2^scale_exponent, rounded half up, saturated; NaN yields 0. One request per
// cycle is accepted while in_stall is low; each result passes the input register,
// then the result register, held there while out_stall holds. The user must write
// configuration only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module float_to_fixed_quantizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_float_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_fixed_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import f2fq_pkg::*;
  cfg_t        cfg;
  logic        s1_valid_r;
  logic [31:0] s1_bits_r;
  logic [31:0] core_res;
  logic        s1_adv;

  f2fq_cfg u_cfg (.clk(clk), .rst_n(rst_n), .wr_en(cfg_valid && cfg_ready),
    .wr_idx(cfg_index), .wr_data(cfg_data), .cfg(cfg));
  f2fq_core u_core (.float_bits(s1_bits_r), .cfg(cfg), .fixed_bits(core_res));

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_adv) out_valid <= s1_valid_r;
      if (!in_stall) s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_bits_r <= in_float_bits;
    if (s1_adv && s1_valid_r) out_fixed_bits <= core_res;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fixed_bits))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid)
    else $error("stall without full pipeline");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_valid)
    else $error("request lost between stages");
endmodule
`default_nettype wire

// ----- hdl/f2fq_cfg.sv -----
// Configuration register file with width clamping.
`timescale 1ns / 1ps
`default_nettype none
module f2fq_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [f2fq_pkg::CFG_IDX_W-1:0] wr_idx,
  input  wire logic [31:0]                    wr_data,
  output f2fq_pkg::cfg_t                      cfg
);
  import f2fq_pkg::*;
  logic signed [6:0] scale_exp_r;
  logic [5:0]        out_width_r;
  logic              signed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_exp_r <= SCALE_EXP_RST;
      out_width_r <= OUT_WIDTH_RST;
      signed_r    <= SIGNED_RST;
    end else if (wr_en) begin
      if (wr_idx == REG_SCALE_EXP) scale_exp_r <= wr_data[6:0];
      if (wr_idx == REG_OUT_WIDTH) out_width_r <= wr_data[5:0];
      if (wr_idx == REG_SIGNED)    signed_r    <= wr_data[0];
    end
  end

  always_comb begin
    cfg.scale_exp = scale_exp_r;
    cfg.is_signed = signed_r;
    if (out_width_r < 6'd2)       cfg.width = 6'd2;
    else if (out_width_r > 6'd32) cfg.width = 6'd32;
    else                          cfg.width = out_width_r;
  end
endmodule
`default_nettype wire

// ----- hdl/f2fq_core.sv -----
// Combinational scale, round and saturate of one float word.
`timescale 1ns / 1ps
`default_nettype none
module f2fq_core (
  input  wire logic [31:0]    float_bits,
  input  wire f2fq_pkg::cfg_t cfg,
  output logic [31:0]         fixed_bits
);
  import f2fq_pkg::*;
  logic        neg, is_nan, is_inf, big;
  logic [7:0]  ex;
  logic [23:0] man;
  logic signed [9:0] k;
  logic [5:0]  n;
  logic [40:0] q;        // magnitude; values too large for 41 bits set big instead
  logic [63:0] shl;
  logic [63:0] rnd;
  logic [32:0] lim, mask;
  logic [32:0] qs;

  always_comb begin
    neg    = float_bits[31];
    ex     = float_bits[30:23];
    is_nan = (ex == 8'hFF) && (float_bits[22:0] != 23'd0);
    is_inf = (ex == 8'hFF) && (float_bits[22:0] == 23'd0);
    man    = {(ex != 8'd0), float_bits[22:0]};
    k      = ((ex == 8'd0) ? -10'sd149 : ($signed({2'b00, ex}) - 10'sd150))
             + 10'(cfg.scale_exp);
    n      = 6'd0;
    shl    = 64'd0;
    rnd    = 64'd0;
    big    = 1'b0;
    q      = 41'd0;
    if (is_inf) begin
      big = 1'b1;
    end else if (man == 24'd0) begin
      q = 41'd0;
    end else if (k >= 10'sd0) begin
      if (k > 10'sd17) big = 1'b1;    // 24-bit mantissa beyond 41 bits
      else begin
        shl = {40'd0, man} << k[4:0];
        q   = shl[40:0];
      end
    end else if (k <= -10'sd60) begin
      q = 41'd0;
    end else begin
      n   = 6'(-k);
      rnd = ({40'd0, man} + (64'd1 << (n - 6'd1)) - {63'd0, neg}) >> n;
      q   = rnd[40:0];
    end
    mask = (33'd1 << cfg.width) - 33'd1;
    lim  = 33'd1 << (cfg.width - 6'd1);
    if (big || q[40:33] != 8'd0) qs = 33'h1_FFFF_FFFF;
    else                          qs = q[32:0];
    if (is_nan) begin
      fixed_bits = 32'd0;
    end else if (cfg.is_signed) begin
      if (neg) begin
        if (qs > lim) qs = lim;
        fixed_bits = 32'((33'd0 - qs) & mask);
      end else begin
        if (qs > lim - 33'd1) qs = lim - 33'd1;
        fixed_bits = qs[31:0];
      end
    end else if (neg) begin
      fixed_bits = 32'd0;
    end else begin
      fixed_bits = (qs > mask) ? mask[31:0] : qs[31:0];
    end
  end
endmodule
`default_nettype wire
